/* hdl/i2c_seq_pkg.sv */
package i2c_seq_pkg;

    // Bus bit count per byte
    localparam int unsigned BITS_PER_BYTE = 8;

    // Configuration port geometry
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_TICKS      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_POLL_LIMIT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_POST_WRITE_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [15:0] PHASE_TICKS_RST      = 16'd20;
    localparam logic [7:0]  ACK_POLL_LIMIT_RST   = 8'd250;
    localparam logic [15:0] POST_WRITE_TICKS_RST = 16'd40;

    // Opcodes on the command bus
    localparam logic [2:0] OPC_START = 3'd0;
    localparam logic [2:0] OPC_STOP  = 3'd1;
    localparam logic [2:0] OPC_WRITE = 3'd2;
    localparam logic [2:0] OPC_WAIT  = 3'd3;
    localparam logic [2:0] OPC_READ  = 3'd4;

    // Sequence being executed by the bus engine
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_WAIT  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    // Outcome of one phase action
    typedef enum logic [1:0] {
        ACT_END   = 2'd0,
        ACT_POLL  = 2'd1,
        ACT_DELAY = 2'd2,
        ACT_ZERO  = 2'd3
    } act_t;

    // Classified tick as queued between front and back
    typedef struct packed {
        logic       legal;
        op_t        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } entry_t;

    // Configuration bundle
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_poll_limit;
        logic [15:0] post_write_ticks;
    } cfg_t;

    // One result per tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } result_t;

endpackage

/* hdl/i2c_seq_if.sv */
interface i2c_seq_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, input ready);
    modport sink (input valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2c_seq_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
                    input ready);
    modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte,
                  output ready);
endinterface

/* hdl/i2c_seq_front.sv */
module i2c_seq_front (
    i2c_seq_in_if.sink          in_ch,
    output logic                push_valid,
    input  logic                push_ready,
    output i2c_seq_pkg::entry_t push_data
);
    import i2c_seq_pkg::*;

    // Handshake passes straight to the queue
    assign push_valid = in_ch.valid;
    assign in_ch.ready = push_ready;

    // Classify the command: only a flagged, known opcode starts a sequence
    always_comb
    begin
        push_data.legal    = 1'b0;
        push_data.op       = OP_IDLE;
        push_data.tx_byte  = in_ch.tx_byte;
        push_data.send_ack = in_ch.send_ack;
        push_data.sda_in   = in_ch.sda_in;
        if (in_ch.cmd_valid)
        begin
            push_data.legal = 1'b1;
            case (in_ch.opcode)
                OPC_START: push_data.op = OP_START;
                OPC_STOP:  push_data.op = OP_STOP;
                OPC_WRITE: push_data.op = OP_WRITE;
                OPC_WAIT:  push_data.op = OP_WAIT;
                OPC_READ:  push_data.op = OP_READ;
                default:   push_data.legal = 1'b0;
            endcase
        end
    end

endmodule

/* hdl/i2c_seq_fifo.sv */
module i2c_seq_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  i2c_seq_pkg::entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output i2c_seq_pkg::entry_t pop_data
);
    import i2c_seq_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/i2c_seq_back.sv */
module i2c_seq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  i2c_seq_pkg::cfg_t   cfg,
    input  logic                head_valid,
    output logic                head_ready,
    input  i2c_seq_pkg::entry_t head,
    i2c_seq_out_if.source       out_ch
);
    import i2c_seq_pkg::*;

    // Bus engine state
    op_t         op_reg, op_next;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  poll_reg, poll_next;
    logic [7:0]  sr_reg, sr_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drv_reg, drv_next;
    logic        chain_reg, chain_next;

    // Output stage
    result_t     out_res_reg, out_res_next;
    logic        out_valid_reg, out_valid_next;

    logic        slot_free;
    logic        work_en;
    logic        emit;
    logic        done;
    logic        run;
    act_t        act;
    logic [15:0] delay_val;
    op_t         op_w;
    logic [3:0]  step_w;
    logic        start_cmd;

    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign work_en    = head_valid && slot_free;
    assign start_cmd  = !chain_reg && (op_reg == OP_IDLE) && head.legal;
    assign op_w       = start_cmd ? head.op : op_reg;
    assign step_w     = start_cmd ? 4'd0 : step_reg;

    // Next state: one phase action per cycle while the head tick can be worked, zero-length phases chain over cycles
    always_comb
    begin
        op_next    = op_w;
        step_next  = step_w;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        poll_next  = poll_reg;
        sr_next    = (start_cmd && head.op == OP_WRITE) ? head.tx_byte : sr_reg;
        ack_next   = (start_cmd && head.op == OP_READ) ? head.send_ack : ack_reg;
        rx_next    = rx_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        chain_next = 1'b0;
        run        = 1'b0;
        act        = ACT_END;
        delay_val  = cfg.phase_ticks;
        emit       = 1'b1;
        done       = 1'b0;

        if (!chain_reg && op_reg == OP_IDLE)
        begin
            run = head.legal;
        end
        else if (!chain_reg && tick_reg != '0)
        begin
            tick_next = tick_reg - 16'd1;
        end
        else
        begin
            run = 1'b1;
        end

        if (run)
        begin
            case (op_w)
                OP_START:
                begin
                    act = ACT_DELAY;
                    step_next = step_w + 4'd1;
                    case (step_w)
                        4'd0:
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            drv_next = 1'b1;
                        end
                        4'd1: sda_next = 1'b0;
                        4'd2: ;
                        4'd3: scl_next = 1'b0;
                        4'd4: ;
                        default:
                        begin
                            act = ACT_END;
                            step_next = step_w;
                        end
                    endcase
                end
                OP_STOP:
                begin
                    act = ACT_DELAY;
                    step_next = step_w + 4'd1;
                    case (step_w)
                        4'd0:
                        begin
                            drv_next = 1'b1;
                            scl_next = 1'b0;
                        end
                        4'd1: sda_next = 1'b0;
                        4'd2: scl_next = 1'b1;
                        4'd3: sda_next = 1'b1;
                        default:
                        begin
                            act = ACT_END;
                            step_next = step_w;
                        end
                    endcase
                end
                OP_WAIT:
                begin
                    case (step_w)
                        4'd0:
                        begin
                            drv_next = 1'b0;
                            sda_next = 1'b1;
                            step_next = 4'd1;
                            act = ACT_DELAY;
                        end
                        4'd1:
                        begin
                            scl_next = 1'b1;
                            poll_next = '0;
                            step_next = 4'd2;
                            act = ACT_DELAY;
                        end
                        4'd2:
                        begin
                            // Poll while SDA stays high and the limit is not reached
                            if (head.sda_in && poll_reg < cfg.ack_poll_limit)
                            begin
                                poll_next = poll_reg + 8'd1;
                                act = ACT_POLL;
                            end
                            else
                            begin
                                step_next = 4'd3;
                                act = ACT_ZERO;
                            end
                        end
                        4'd3:
                        begin
                            scl_next = 1'b0;
                            step_next = 4'd4;
                            act = ACT_DELAY;
                        end
                        default: act = ACT_END;
                    endcase
                end
                OP_WRITE:
                begin
                    case (step_w)
                        4'd0:
                        begin
                            scl_next = 1'b0;
                            drv_next = 1'b1;
                            bit_next = '0;
                            step_next = 4'd1;
                            act = ACT_ZERO;
                        end
                        4'd1:
                        begin
                            step_next = 4'd2;
                            act = ACT_DELAY;
                        end
                        4'd2:
                        begin
                            sda_next = sr_next[7];
                            sr_next = {sr_next[6:0], 1'b0};
                            step_next = 4'd3;
                            act = ACT_DELAY;
                        end
                        4'd3:
                        begin
                            scl_next = 1'b1;
                            step_next = 4'd4;
                            act = ACT_DELAY;
                        end
                        4'd4:
                        begin
                            scl_next = 1'b0;
                            bit_next = bit_reg + 4'd1;
                            step_next = (bit_next < 4'(BITS_PER_BYTE)) ? 4'd1 : 4'd5;
                            act = ACT_ZERO;
                        end
                        4'd5:
                        begin
                            step_next = 4'd6;
                            delay_val = cfg.post_write_ticks;
                            act = ACT_DELAY;
                        end
                        default: act = ACT_END;
                    endcase
                end
                OP_READ:
                begin
                    case (step_w)
                        4'd0:
                        begin
                            scl_next = 1'b0;
                            drv_next = 1'b0;
                            sda_next = 1'b1;
                            bit_next = '0;
                            sr_next = '0;
                            step_next = 4'd1;
                            act = ACT_ZERO;
                        end
                        4'd1:
                        begin
                            scl_next = 1'b0;
                            step_next = 4'd2;
                            act = ACT_DELAY;
                        end
                        4'd2:
                        begin
                            scl_next = 1'b1;
                            step_next = 4'd3;
                            act = ACT_DELAY;
                        end
                        4'd3:
                        begin
                            sr_next = {sr_reg[6:0], head.sda_in};
                            bit_next = bit_reg + 4'd1;
                            step_next = (bit_next < 4'(BITS_PER_BYTE)) ? 4'd1 : 4'd4;
                            act = ACT_DELAY;
                        end
                        4'd4:
                        begin
                            rx_next = sr_reg;
                            scl_next = 1'b0;
                            drv_next = 1'b1;
                            sda_next = !ack_reg;
                            step_next = 4'd5;
                            act = ACT_DELAY;
                        end
                        4'd5:
                        begin
                            scl_next = 1'b1;
                            step_next = 4'd6;
                            act = ACT_DELAY;
                        end
                        4'd6:
                        begin
                            scl_next = 1'b0;
                            step_next = 4'd7;
                            act = ACT_ZERO;
                        end
                        default: act = ACT_END;
                    endcase
                end
                default: act = ACT_END;
            endcase

            // A phase of zero ticks chains into the next action
            if (act == ACT_DELAY && delay_val == '0)
            begin
                act = ACT_ZERO;
            end

            case (act)
                ACT_END:
                begin
                    op_next   = OP_IDLE;
                    step_next = '0;
                    tick_next = '0;
                    done      = 1'b1;
                end
                ACT_POLL:  tick_next = '0;
                ACT_DELAY: tick_next = delay_val - 16'd1;
                ACT_ZERO:
                begin
                    chain_next = 1'b1;
                    emit = 1'b0;
                end
                default:   tick_next = '0;
            endcase
        end
    end

    // Outputs: result register and queue pop
    always_comb
    begin
        head_ready     = slot_free && emit;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_res_next   = out_res_reg;
        if (work_en && emit)
        begin
            out_valid_next         = 1'b1;
            out_res_next.scl_level = scl_next;
            out_res_next.sda_level = sda_next;
            out_res_next.sda_drive = drv_next;
            out_res_next.busy_res  = (op_next != OP_IDLE);
            out_res_next.done_res  = done;
            out_res_next.rx_byte   = rx_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.scl_level = out_res_reg.scl_level;
    assign out_ch.sda_level = out_res_reg.sda_level;
    assign out_ch.sda_drive = out_res_reg.sda_drive;
    assign out_ch.busy_res  = out_res_reg.busy_res;
    assign out_ch.done_res  = out_res_reg.done_res;
    assign out_ch.rx_byte   = out_res_reg.rx_byte;

    // Engine registers advance only when the head tick can be worked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            tick_reg  <= '0;
            poll_reg  <= '0;
            sr_reg    <= '0;
            ack_reg   <= 1'b0;
            rx_reg    <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            chain_reg <= 1'b0;
        end
        else if (work_en)
        begin
            op_reg    <= op_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            poll_reg  <= poll_next;
            sr_reg    <= sr_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

/* hdl/i2c_master_byte_sequencer_top.sv */
// A tick's result is registered: the tick passes through the queue and then the result
// register. Each zero-delay action chained inside the tick keeps the tick at the queue head,
// one action a cycle while the result register is free. Throughput: one tick per cycle while
// the result register is free; a chain holds the queue until a delay, a poll or the end.
// Reset: asynchronous, active low; bus idle with SCL high and SDA driven high, config
// registers at 20 / 250 / 40, queue and result register empty.
module i2c_master_byte_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [i2c_seq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [i2c_seq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    i2c_seq_in_if.sink                         in_ch,
    i2c_seq_out_if.source                      out_ch
);
    import i2c_seq_pkg::*;

    cfg_t   cfg_reg;
    logic   push_valid, push_ready;
    entry_t push_data;
    logic   head_valid, head_ready;
    entry_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks      <= PHASE_TICKS_RST;
            cfg_reg.ack_poll_limit   <= ACK_POLL_LIMIT_RST;
            cfg_reg.post_write_ticks <= POST_WRITE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PHASE_TICKS:      cfg_reg.phase_ticks      <= cfg_wdata;
                CFG_ACK_POLL_LIMIT:   cfg_reg.ack_poll_limit   <= cfg_wdata[7:0];
                CFG_POST_WRITE_TICKS: cfg_reg.post_write_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: accept and classify
    i2c_seq_front u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue between front and bus engine
    i2c_seq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head)
    );

    // Back: bus engine and result register
    i2c_seq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head),
        .out_ch     (out_ch)
    );

    // A finishing transaction never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.done_res) |-> !out_ch.busy_res)
        else $error("done_res raised while busy_res still set");

    // SDA is released only with its output register high
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.sda_drive) |-> out_ch.sda_level)
        else $error("SDA released with output register low");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import i2c_seq_pkg::*;

    // Opcodes the block has no sequence for
    localparam logic [2:0] OPC_RSVD_A = 3'd5;
    localparam logic [2:0] OPC_RSVD_B = 3'd6;
    localparam logic [2:0] OPC_RSVD_C = 3'd7;

    // Phase action outcomes besides a plain delay
    localparam int PH_END  = -1;
    localparam int PH_POLL = -2;

    // Cycles without any transaction before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the one long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    // Ticks long enough to keep SDA high for a whole wait
    localparam int SDA_ALWAYS_HIGH = 100000;

    // One bus tick as offered on the input channel
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_item_t;

    // Sequencer state plus its configuration
    typedef struct {
        op_t         op;
        logic [3:0]  step;
        logic [3:0]  bits;
        logic [15:0] ticks;
        logic [7:0]  polls;
        logic [7:0]  shreg;
        logic        ack_sel;
        logic [7:0]  rx;
        logic        scl;
        logic        sda;
        logic        drv;
        logic [15:0] phase_ticks;
        logic [7:0]  poll_limit;
        logic [15:0] post_ticks;
    } bus_model_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    i2c_seq_in_if  in_ch ();
    i2c_seq_out_if out_ch ();

    i2c_master_byte_sequencer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    tick_item_t pending_ticks[$];
    result_t    expected_results[$];
    bus_model_t bus_check;
    bus_model_t bus_plan;
    int         ticks_planned;
    int         errors;
    int         quiet_cycles;
    int         idle_mode;
    int         hold_left;
    logic       in_taken;
    logic       pressure_req;
    logic       pressure_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Bus sequencer prediction
    // ---------------------------------------------------------------
    function automatic bus_model_t bus_reset();
        bus_model_t m;
        m.op          = OP_IDLE;
        m.step        = '0;
        m.bits        = '0;
        m.ticks       = '0;
        m.polls       = '0;
        m.shreg       = '0;
        m.ack_sel     = 1'b0;
        m.rx          = '0;
        m.scl         = 1'b1;
        m.sda         = 1'b1;
        m.drv         = 1'b1;
        m.phase_ticks = PHASE_TICKS_RST;
        m.poll_limit  = ACK_POLL_LIMIT_RST;
        m.post_ticks  = POST_WRITE_TICKS_RST;
        return m;
    endfunction

    function automatic void set_reg(inout bus_model_t m, input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PHASE_TICKS:      m.phase_ticks = val;
            CFG_ACK_POLL_LIMIT:   m.poll_limit  = val[7:0];
            CFG_POST_WRITE_TICKS: m.post_ticks  = val;
            default: ;
        endcase
    endfunction

    // One phase action: returns its delay, PH_END or PH_POLL
    function automatic int bus_phase(inout bus_model_t m, input logic sda_pin);
        int d;
        d = int'(m.phase_ticks);
        case (m.op)
            OP_START:
            begin
                case (m.step)
                    4'd0:
                    begin
                        m.scl = 1'b1;
                        m.sda = 1'b1;
                        m.drv = 1'b1;
                    end
                    4'd1: m.sda = 1'b0;
                    4'd3: m.scl = 1'b0;
                    4'd2, 4'd4: ;
                    default: return PH_END;
                endcase
                m.step = m.step + 4'd1;
                return d;
            end
            OP_STOP:
            begin
                case (m.step)
                    4'd0:
                    begin
                        m.drv = 1'b1;
                        m.scl = 1'b0;
                    end
                    4'd1: m.sda = 1'b0;
                    4'd2: m.scl = 1'b1;
                    4'd3: m.sda = 1'b1;
                    default: return PH_END;
                endcase
                m.step = m.step + 4'd1;
                return d;
            end
            OP_WAIT:
            begin
                case (m.step)
                    4'd0:
                    begin
                        m.drv  = 1'b0;
                        m.sda  = 1'b1;
                        m.step = 4'd1;
                        return d;
                    end
                    4'd1:
                    begin
                        m.scl   = 1'b1;
                        m.polls = '0;
                        m.step  = 4'd2;
                        return d;
                    end
                    4'd2:
                    begin
                        // keep polling while SDA is high and the limit is not reached
                        if (sda_pin && m.polls < m.poll_limit)
                        begin
                            m.polls = m.polls + 8'd1;
                            return PH_POLL;
                        end
                        m.step = 4'd3;
                        return 0;
                    end
                    4'd3:
                    begin
                        m.scl  = 1'b0;
                        m.step = 4'd4;
                        return d;
                    end
                    default: return PH_END;
                endcase
            end
            OP_WRITE:
            begin
                case (m.step)
                    4'd0:
                    begin
                        m.scl  = 1'b0;
                        m.drv  = 1'b1;
                        m.bits = '0;
                        m.step = 4'd1;
                        return 0;
                    end
                    4'd1:
                    begin
                        m.step = 4'd2;
                        return d;
                    end
                    4'd2:
                    begin
                        m.sda   = m.shreg[7];
                        m.shreg = {m.shreg[6:0], 1'b0};
                        m.step  = 4'd3;
                        return d;
                    end
                    4'd3:
                    begin
                        m.scl  = 1'b1;
                        m.step = 4'd4;
                        return d;
                    end
                    4'd4:
                    begin
                        m.scl  = 1'b0;
                        m.bits = m.bits + 4'd1;
                        m.step = (m.bits < BITS_PER_BYTE) ? 4'd1 : 4'd5;
                        return 0;
                    end
                    4'd5:
                    begin
                        m.step = 4'd6;
                        return int'(m.post_ticks);
                    end
                    default: return PH_END;
                endcase
            end
            OP_READ:
            begin
                case (m.step)
                    4'd0:
                    begin
                        m.scl   = 1'b0;
                        m.drv   = 1'b0;
                        m.sda   = 1'b1;
                        m.bits  = '0;
                        m.shreg = '0;
                        m.step  = 4'd1;
                        return 0;
                    end
                    4'd1:
                    begin
                        m.scl  = 1'b0;
                        m.step = 4'd2;
                        return d;
                    end
                    4'd2:
                    begin
                        m.scl  = 1'b1;
                        m.step = 4'd3;
                        return d;
                    end
                    4'd3:
                    begin
                        // sample after the rising SCL edge, MSB first
                        m.shreg = {m.shreg[6:0], sda_pin};
                        m.bits  = m.bits + 4'd1;
                        m.step  = (m.bits < BITS_PER_BYTE) ? 4'd1 : 4'd4;
                        return d;
                    end
                    4'd4:
                    begin
                        m.rx   = m.shreg;
                        m.scl  = 1'b0;
                        m.drv  = 1'b1;
                        m.sda  = ~m.ack_sel;
                        m.step = 4'd5;
                        return d;
                    end
                    4'd5:
                    begin
                        m.scl  = 1'b1;
                        m.step = 4'd6;
                        return d;
                    end
                    4'd6:
                    begin
                        m.scl  = 1'b0;
                        m.step = 4'd7;
                        return 0;
                    end
                    default: return PH_END;
                endcase
            end
            default: return PH_END;
        endcase
    endfunction

    // Chain actions until a delay starts, polling waits, or the sequence ends
    function automatic logic bus_advance(inout bus_model_t m, input logic sda_pin);
        int d;
        while (1'b1)
        begin
            d = bus_phase(m, sda_pin);
            if (d == PH_END)
            begin
                m.op    = OP_IDLE;
                m.step  = '0;
                m.ticks = '0;
                return 1'b1;
            end
            if (d == PH_POLL)
            begin
                m.ticks = '0;
                return 1'b0;
            end
            if (d > 0)
            begin
                m.ticks = 16'(d - 1);
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic result_t bus_tick(inout bus_model_t m, input tick_item_t it);
        result_t r;
        logic    fin;
        fin = 1'b0;
        if (m.op == OP_IDLE)
        begin
            if (it.cmd_valid && it.opcode <= OPC_READ)
            begin
                case (it.opcode)
                    OPC_START: m.op = OP_START;
                    OPC_STOP:  m.op = OP_STOP;
                    OPC_WRITE: m.op = OP_WRITE;
                    OPC_WAIT:  m.op = OP_WAIT;
                    default:   m.op = OP_READ;
                endcase
                m.step  = '0;
                m.ticks = '0;
                if (m.op == OP_WRITE)
                    m.shreg = it.tx_byte;
                if (m.op == OP_READ)
                    m.ack_sel = it.send_ack;
                fin = bus_advance(m, it.sda_in);
            end
        end
        else if (m.ticks != 16'd0)
            m.ticks = m.ticks - 16'd1;
        else
            fin = bus_advance(m, it.sda_in);

        r.scl_level = m.scl;
        r.sda_level = m.sda;
        r.sda_drive = m.drv;
        r.busy_res  = (m.op != OP_IDLE);
        r.done_res  = fin;
        r.rx_byte   = m.rx;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus planning: the plan copy tracks when the block goes idle
    // ---------------------------------------------------------------
    task automatic plan_tick(input logic cv, input logic [2:0] opc, input logic [7:0] tx,
                             input logic ack, input logic sda_pin);
        tick_item_t it;
        it.cmd_valid = cv;
        it.opcode    = opc;
        it.tx_byte   = tx;
        it.send_ack  = ack;
        it.sda_in    = sda_pin;
        void'(bus_tick(bus_plan, it));
        pending_ticks.push_back(it);
        ticks_planned++;
    endtask

    // Issue a command, then tick until it completes; busy ticks carry random
    // commands that must be ignored. sda_hi < 0: random SDA, else high for
    // the first sda_hi ticks and low afterwards.
    task automatic run_cmd(input logic [2:0] opc, input logic [7:0] tx, input logic ack,
                           input int sda_hi);
        int   n;
        logic s;
        n = 0;
        do
        begin
            s = (sda_hi < 0) ? 1'($urandom) : (n < sda_hi);
            if (n == 0)
                plan_tick(1'b1, opc, tx, ack, s);
            else
                plan_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 8'($urandom),
                          1'($urandom), s);
            n++;
        end while (bus_plan.op != OP_IDLE);
    endtask

    // Mostly an early acknowledge, sometimes a slave that never answers
    function automatic int ack_delay();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, 10));
        return int'($urandom_range(11, 300));
    endfunction

    // start, address, acknowledge, data bytes, stop
    task automatic bus_transaction();
        logic [7:0] addr;
        int         n;
        addr = 8'($urandom);
        n    = int'($urandom_range(0, 3));
        run_cmd(OPC_START, 8'($urandom), 1'($urandom), -1);
        run_cmd(OPC_WRITE, addr, 1'($urandom), -1);
        run_cmd(OPC_WAIT, 8'($urandom), 1'($urandom), ack_delay());
        for (int i = 0; i < n; i++)
        begin
            if (addr[0])
                run_cmd(OPC_READ, 8'($urandom), i != n - 1, -1);
            else
            begin
                run_cmd(OPC_WRITE, 8'($urandom), 1'($urandom), -1);
                run_cmd(OPC_WAIT, 8'($urandom), 1'($urandom), ack_delay());
            end
        end
        run_cmd(OPC_STOP, 8'($urandom), 1'($urandom), -1);
    endtask

    task automatic random_phase(input int quota);
        int first;
        first = ticks_planned;
        while (ticks_planned - first < quota)
        begin
            if ($urandom_range(0, 99) < 75)
                bus_transaction();
            else
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                        ($urandom_range(0, 1) != 0) ? -1 : int'($urandom_range(0, 20)));
            // idle gap: ticks with no command, or only unknown opcodes
            repeat ($urandom_range(0, 3))
                plan_tick(1'($urandom), 3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom),
                          1'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        set_reg(bus_plan, idx, val);
        @(posedge clk);
    endtask

    // Wait until every planned tick has been answered, plus a latency margin
    task automatic settle();
        while (pending_ticks.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    function automatic logic sender_rest();
        case (idle_mode)
            1: return $urandom_range(0, 99) < 73;
            3: return $urandom_range(0, 99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_rest();
        case (idle_mode)
            2: return $urandom_range(0, 99) < 73;
            3: return $urandom_range(0, 99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers pending ticks, changes inputs on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(pending_ticks.pop_front());
            // an offer not yet taken stays on the bus unchanged
            if (!(in_ch.valid && !in_taken))
            begin
                if (pending_ticks.size() != 0 && !sender_rest())
                begin
                    in_ch.valid     <= 1'b1;
                    in_ch.cmd_valid <= pending_ticks[0].cmd_valid;
                    in_ch.opcode    <= pending_ticks[0].opcode;
                    in_ch.tx_byte   <= pending_ticks[0].tx_byte;
                    in_ch.send_ack  <= pending_ticks[0].send_ack;
                    in_ch.sda_in    <= pending_ticks[0].sda_in;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pressure_req && !pressure_done)
            begin
                pressure_done <= 1'b1;
                hold_left     <= HOLD_OFF_CYCLES;
                out_ch.ready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ~receiver_rest();
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: checks results, predicts accepted ticks, watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t    got;
        result_t    want;
        tick_item_t it;
        if (rst_n)
        begin
            if (cfg_we)
                set_reg(bus_check, cfg_addr, cfg_wdata);

            if (out_ch.valid && out_ch.ready)
            begin
                got.scl_level = out_ch.scl_level;
                got.sda_level = out_ch.sda_level;
                got.sda_drive = out_ch.sda_drive;
                got.busy_res  = out_ch.busy_res;
                got.done_res  = out_ch.done_res;
                got.rx_byte   = out_ch.rx_byte;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no tick pending: expected none actual %0h",
                             $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
                    check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
                    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                it.cmd_valid = in_ch.cmd_valid;
                it.opcode    = in_ch.opcode;
                it.tx_byte   = in_ch.tx_byte;
                it.send_ack  = in_ch.send_ack;
                it.sda_in    = in_ch.sda_in;
                expected_results.push_back(bus_tick(bus_check, it));
            end
            in_taken <= in_ch.valid && in_ch.ready;

            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL i2c_master_byte_sequencer_top");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int idle_of_phase[6];
        idle_of_phase = '{0, 1, 2, 3, 1, 3};

        cfg_we          = 1'b0;
        cfg_addr        = CFG_PHASE_TICKS;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.cmd_valid = 1'b0;
        in_ch.opcode    = OPC_START;
        in_ch.tx_byte   = '0;
        in_ch.send_ack  = 1'b0;
        in_ch.sda_in    = 1'b1;
        out_ch.ready    = 1'b0;
        in_taken        = 1'b0;
        pressure_req    = 1'b0;
        pressure_done   = 1'b0;
        hold_left       = 0;
        quiet_cycles    = 0;
        errors          = 0;
        ticks_planned   = 0;
        idle_mode       = 0;
        bus_check       = bus_reset();
        bus_plan        = bus_reset();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset configuration, receiver held off once at the start
        pressure_req = 1'b1;
        plan_tick(1'b0, OPC_START, 8'h00, 1'b0, 1'b1);
        run_cmd(OPC_RSVD_A, 8'hFF, 1'b1, -1);
        run_cmd(OPC_RSVD_B, 8'h00, 1'b0, -1);
        run_cmd(OPC_RSVD_C, 8'h5A, 1'b1, -1);
        run_cmd(OPC_START, 8'h00, 1'b0, -1);
        run_cmd(OPC_WAIT, 8'h00, 1'b0, 0);
        run_cmd(OPC_STOP, 8'h00, 1'b0, -1);
        settle();

        // Zero-length phases, no polling, no pause after a write
        write_reg(CFG_PHASE_TICKS, 16'd0);
        write_reg(CFG_ACK_POLL_LIMIT, 16'd0);
        write_reg(CFG_POST_WRITE_TICKS, 16'd0);
        idle_mode = 3;
        run_cmd(OPC_START, 8'h00, 1'b0, -1);
        run_cmd(OPC_WRITE, 8'hA5, 1'b0, -1);
        run_cmd(OPC_WAIT, 8'h00, 1'b0, 5);
        run_cmd(OPC_READ, 8'h00, 1'b0, -1);
        run_cmd(OPC_READ, 8'h00, 1'b1, 0);
        run_cmd(OPC_RSVD_B, 8'h00, 1'b1, -1);
        run_cmd(OPC_WRITE, 8'hFF, 1'b1, -1);
        run_cmd(OPC_STOP, 8'h00, 1'b0, -1);
        settle();

        // Full poll limit with a slave that never acknowledges, then byte traffic
        write_reg(CFG_ACK_POLL_LIMIT, 16'd255);
        write_reg(CFG_PHASE_TICKS, 16'd1);
        idle_mode = 2;
        run_cmd(OPC_WAIT, 8'h00, 1'b0, SDA_ALWAYS_HIGH);
        run_cmd(OPC_WRITE, 8'hFF, 1'b0, -1);
        run_cmd(OPC_WAIT, 8'h00, 1'b0, 0);
        run_cmd(OPC_WRITE, 8'h00, 1'b1, -1);
        run_cmd(OPC_WAIT, 8'h00, 1'b0, 3);
        run_cmd(OPC_READ, 8'h00, 1'b1, -1);
        run_cmd(OPC_READ, 8'h00, 1'b0, SDA_ALWAYS_HIGH);
        run_cmd(OPC_READ, 8'hFF, 1'b1, 0);
        run_cmd(OPC_STOP, 8'h00, 1'b0, -1);
        settle();

        // Random traffic over several configurations and idle patterns
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_PHASE_TICKS, 16'($urandom_range(0, 3)));
            write_reg(CFG_ACK_POLL_LIMIT,
                      ($urandom_range(0, 9) == 0) ? 16'd255 : 16'($urandom_range(0, 6)));
            write_reg(CFG_POST_WRITE_TICKS, 16'($urandom_range(0, 8)));
            idle_mode = idle_of_phase[p];
            random_phase(50);
            settle();
        end

        if (errors == 0)
            $display("PASS i2c_master_byte_sequencer_top");
        else
            $display("FAIL i2c_master_byte_sequencer_top");
        $finish;
    end

endmodule
